[hdl/psv_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, widths, register codes and stage types of the pixel scattering vector block.
package psv_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int IDX_W      = 12;
    localparam int PS_W       = 20;
    localparam int BEAM_W     = 27;
    localparam int DIST_W     = 27;
    localparam int INV_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WL     = 3'd4;

    localparam logic [PS_W-1:0]   RST_PIXEL_SIZE = 20'd6554;
    localparam logic [DIST_W-1:0] RST_DISTANCE   = 27'd6553600;
    localparam logic [INV_W-1:0]  RST_INV_WL     = 20'd65536;

    localparam int PROD_W = IDX_W + PS_W;
    localparam int POS_W  = PROD_W + 2;
    localparam int MAG_W  = PROD_W + 1;
    localparam int LO_W   = 17;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int NUM_W  = ROOT_W + INV_W + 1;
    localparam int Q_BITS = 20;
    localparam int S_LIM  = 1 << Q_BITS;
    localparam int SXY_W  = 22;
    localparam int SZ_W   = 21;

    typedef struct packed {
        logic              x_neg;
        logic [MAG_W-1:0]  ax;
        logic              y_neg;
        logic [MAG_W-1:0]  ay;
        logic [DIST_W-1:0] z;
    } t_side;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_dmeta;

endpackage

[hdl/psv_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one root bit per stage.
module psv_sqrt
    import psv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SUM_W-1:0]  i_sum,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic              r_valid [ROOT_W];
    logic [SUM_W-1:0]  r_rem   [ROOT_W];
    logic [ROOT_W-1:0] r_root  [ROOT_W];
    t_side             r_side  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        localparam int B = ROOT_W - 1 - i;
        logic              v_in;
        logic [SUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        t_side             side_in;
        logic [SUM_W+1:0]  trial;
        logic              take;
        logic [SUM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (i == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_sum;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[i-1];
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign side_in = r_side[i-1];
        end

        always_comb begin
            trial  = ((SUM_W+2)'(root_in) << (B + 1)) | ((SUM_W+2)'(1) << (2 * B));
            take   = (SUM_W+2)'(rem_in) >= trial;
            n_rem  = take ? rem_in - trial[SUM_W-1:0] : rem_in;
            n_root = take ? (root_in | (ROOT_W'(1) << B)) : root_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_valid[i] <= v_in;
            end
            if (i_en) begin
                r_rem[i]  <= n_rem;
                r_root[i] <= n_root;
                r_side[i] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

[hdl/psv_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider with overflow detection and saturation, one quotient bit per stage.
module psv_div
    import psv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    input  t_dmeta            i_meta,
    output logic              o_valid,
    output logic [Q_BITS:0]   o_mag,
    output t_dmeta            o_meta
);

    logic              r_valid [Q_BITS+1];
    logic [NUM_W-1:0]  r_rem   [Q_BITS+1];
    logic [ROOT_W-1:0] r_den   [Q_BITS+1];
    logic [Q_BITS-1:0] r_quo   [Q_BITS+1];
    logic              r_ovf   [Q_BITS+1];
    t_dmeta            r_meta  [Q_BITS+1];

    logic n_ovf;

    assign n_ovf = i_num[NUM_W-1:Q_BITS] >= (NUM_W-Q_BITS)'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_quo[0]  <= '0;
            r_ovf[0]  <= n_ovf;
            r_meta[0] <= i_meta;
        end
    end

    for (genvar i = 1; i <= Q_BITS; i++) begin : g_stage
        localparam int B = Q_BITS - i;
        logic [NUM_W-1:0]  dsh;
        logic              take;
        logic [NUM_W-1:0]  n_rem;
        logic [Q_BITS-1:0] n_quo;

        always_comb begin
            dsh   = NUM_W'(r_den[i-1]) << B;
            take  = r_rem[i-1] >= dsh;
            n_rem = take ? r_rem[i-1] - dsh : r_rem[i-1];
            n_quo = take ? (r_quo[i-1] | (Q_BITS'(1) << B)) : r_quo[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_valid[i] <= r_valid[i-1];
            end
            if (i_en) begin
                r_rem[i]  <= n_rem;
                r_den[i]  <= r_den[i-1];
                r_quo[i]  <= n_quo;
                r_ovf[i]  <= r_ovf[i-1];
                r_meta[i] <= r_meta[i-1];
            end
        end
    end

    assign o_valid = r_valid[Q_BITS];
    assign o_mag   = r_ovf[Q_BITS] ? (Q_BITS+1)'(S_LIM) : {1'b0, r_quo[Q_BITS]};
    assign o_meta  = r_meta[Q_BITS];

endmodule

[hdl/pixel_scattering_vector_top.sv]
`timescale 1ns / 1ps
// Top level of the pixel scattering vector pipeline with configuration registers and output skid.
// A request is registered through r1 to r5, the square root, r6 to r8 and the dividers into the output register.
// Throughput: one request per cycle while o_stall is low; the 34-stage square root and the
// 21-stage dividers each retire one item per clock while en is high.
// Reset is synchronous and active low; it empties the pipeline and loads the register defaults.
module pixel_scattering_vector_top
    import psv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [IDX_W-1:0]      i_row,
    input  logic [IDX_W-1:0]      i_column,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SXY_W-1:0]      o_s_x,
    output logic [SXY_W-1:0]      o_s_y,
    output logic [SZ_W-1:0]       o_s_z
);

    logic [PS_W-1:0]   r_pixel_size;
    logic [BEAM_W-1:0] r_beam_x;
    logic [BEAM_W-1:0] r_beam_y;
    logic [DIST_W-1:0] r_distance;
    logic [INV_W-1:0]  r_inv_wl;

    logic en;

    logic [IDX_W-1:0] row_c;
    logic [IDX_W-1:0] col_c;

    logic              r1_v;
    logic [PROD_W-1:0] r1_px;
    logic [PROD_W-1:0] r1_py;

    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic             r2_v;
    t_side            r2_side;

    logic                    r3_v;
    logic [2*HI_W-1:0]       r3_xhh;
    logic [HI_W+LO_W-1:0]    r3_xhl;
    logic [2*LO_W-1:0]       r3_xll;
    logic [2*HI_W-1:0]       r3_yhh;
    logic [HI_W+LO_W-1:0]    r3_yhl;
    logic [2*LO_W-1:0]       r3_yll;
    logic [2*DIST_W-1:0]     r3_zz;
    t_side                   r3_side;

    logic                r4_v;
    logic [SQ_W-1:0]     r4_xsq;
    logic [SQ_W-1:0]     r4_ysq;
    logic [2*DIST_W-1:0] r4_zz;
    t_side               r4_side;

    logic             r5_v;
    logic [SUM_W-1:0] r5_sum;
    t_side            r5_side;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    logic              r6_v;
    logic [ROOT_W-1:0] r6_len;
    logic [ROOT_W-1:0] r6_dz;
    logic              r6_zero;
    t_side             r6_side;

    logic                    r7_v;
    logic [MAG_W+INV_W-1:0]  r7_px;
    logic [MAG_W+INV_W-1:0]  r7_py;
    logic [ROOT_W+INV_W-1:0] r7_pz;
    logic [ROOT_W-1:0]       r7_len;
    logic                    r7_zero;
    logic                    r7_xneg;
    logic                    r7_yneg;

    logic              r8_v;
    logic [NUM_W-1:0]  r8_nx;
    logic [NUM_W-1:0]  r8_ny;
    logic [NUM_W-1:0]  r8_nz;
    logic [ROOT_W-1:0] r8_len;
    t_dmeta            r8_mx;
    t_dmeta            r8_my;
    t_dmeta            r8_mz;

    logic            dx_valid;
    logic            dy_valid;
    logic            dz_valid;
    logic [Q_BITS:0] dx_mag;
    logic [Q_BITS:0] dy_mag;
    logic [Q_BITS:0] dz_mag;
    t_dmeta          dx_meta;
    t_dmeta          dy_meta;
    t_dmeta          dz_meta;

    logic             push;
    logic [SXY_W-1:0] p_sx;
    logic [SXY_W-1:0] p_sy;
    logic [SZ_W-1:0]  p_sz;

    logic             r_o_valid;
    logic [SXY_W-1:0] r_o_sx;
    logic [SXY_W-1:0] r_o_sy;
    logic [SZ_W-1:0]  r_o_sz;
    logic             r_sk_valid;
    logic [SXY_W-1:0] r_sk_sx;
    logic [SXY_W-1:0] r_sk_sy;
    logic [SZ_W-1:0]  r_sk_sz;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_size <= RST_PIXEL_SIZE;
            r_beam_x     <= '0;
            r_beam_y     <= '0;
            r_distance   <= RST_DISTANCE;
            r_inv_wl     <= RST_INV_WL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PIXEL_SIZE: r_pixel_size <= i_cfg_data[PS_W-1:0];
                REG_BEAM_X:     r_beam_x     <= i_cfg_data[BEAM_W-1:0];
                REG_BEAM_Y:     r_beam_y     <= i_cfg_data[BEAM_W-1:0];
                REG_DISTANCE:   r_distance   <= i_cfg_data[DIST_W-1:0];
                REG_INV_WL:     r_inv_wl     <= i_cfg_data[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign en      = !r_sk_valid;
    assign o_stall = r_sk_valid;

    assign row_c = (32'(i_row) >= MAX_DIM) ? IDX_W'(MAX_DIM - 1) : i_row;
    assign col_c = (32'(i_column) >= MAX_DIM) ? IDX_W'(MAX_DIM - 1) : i_column;

    assign x_pos = $signed({2'b00, r1_px}) - POS_W'($signed(r_beam_x));
    assign y_pos = $signed({2'b00, r1_py}) - POS_W'($signed(r_beam_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
        if (en) begin
            r1_px <= PROD_W'(col_c) * PROD_W'(r_pixel_size);
            r1_py <= PROD_W'(row_c) * PROD_W'(r_pixel_size);

            r2_side.x_neg <= x_pos[POS_W-1];
            r2_side.ax    <= x_pos[POS_W-1] ? MAG_W'(-x_pos) : x_pos[MAG_W-1:0];
            r2_side.y_neg <= y_pos[POS_W-1];
            r2_side.ay    <= y_pos[POS_W-1] ? MAG_W'(-y_pos) : y_pos[MAG_W-1:0];
            r2_side.z     <= r_distance;

            r3_xhh  <= (2*HI_W)'(r2_side.ax[MAG_W-1:LO_W]) * (2*HI_W)'(r2_side.ax[MAG_W-1:LO_W]);
            r3_xhl  <= (HI_W+LO_W)'(r2_side.ax[MAG_W-1:LO_W]) * (HI_W+LO_W)'(r2_side.ax[LO_W-1:0]);
            r3_xll  <= (2*LO_W)'(r2_side.ax[LO_W-1:0]) * (2*LO_W)'(r2_side.ax[LO_W-1:0]);
            r3_yhh  <= (2*HI_W)'(r2_side.ay[MAG_W-1:LO_W]) * (2*HI_W)'(r2_side.ay[MAG_W-1:LO_W]);
            r3_yhl  <= (HI_W+LO_W)'(r2_side.ay[MAG_W-1:LO_W]) * (HI_W+LO_W)'(r2_side.ay[LO_W-1:0]);
            r3_yll  <= (2*LO_W)'(r2_side.ay[LO_W-1:0]) * (2*LO_W)'(r2_side.ay[LO_W-1:0]);
            r3_zz   <= (2*DIST_W)'(r2_side.z) * (2*DIST_W)'(r2_side.z);
            r3_side <= r2_side;

            r4_xsq  <= (SQ_W'(r3_xhh) << (2*LO_W)) + (SQ_W'(r3_xhl) << (LO_W+1)) + SQ_W'(r3_xll);
            r4_ysq  <= (SQ_W'(r3_yhh) << (2*LO_W)) + (SQ_W'(r3_yhl) << (LO_W+1)) + SQ_W'(r3_yll);
            r4_zz   <= r3_zz;
            r4_side <= r3_side;

            r5_sum  <= SUM_W'(r4_xsq) + SUM_W'(r4_ysq) + SUM_W'(r4_zz);
            r5_side <= r4_side;
        end
    end

    psv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_sum   (r5_sum),
        .i_side  (r5_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (en) begin
            r6_v <= sq_valid;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
        if (en) begin
            r6_len  <= sq_root;
            r6_dz   <= sq_root - ROOT_W'(sq_side.z);
            r6_zero <= sq_root == '0;
            r6_side <= sq_side;

            r7_px   <= (MAG_W+INV_W)'(r6_side.ax) * (MAG_W+INV_W)'(r_inv_wl);
            r7_py   <= (MAG_W+INV_W)'(r6_side.ay) * (MAG_W+INV_W)'(r_inv_wl);
            r7_pz   <= (ROOT_W+INV_W)'(r6_dz) * (ROOT_W+INV_W)'(r_inv_wl);
            r7_len  <= r6_len;
            r7_zero <= r6_zero;
            r7_xneg <= r6_side.x_neg;
            r7_yneg <= r6_side.y_neg;

            r8_nx   <= NUM_W'(r7_px) + NUM_W'(r7_len >> 1);
            r8_ny   <= NUM_W'(r7_py) + NUM_W'(r7_len >> 1);
            r8_nz   <= NUM_W'(r7_pz) + NUM_W'(r7_len >> 1);
            r8_len  <= r7_len;
            r8_mx   <= '{neg: r7_xneg, zero: r7_zero};
            r8_my   <= '{neg: r7_yneg, zero: r7_zero};
            r8_mz   <= '{neg: 1'b1, zero: r7_zero};
        end
    end

    psv_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_num   (r8_nx),
        .i_den   (r8_len),
        .i_meta  (r8_mx),
        .o_valid (dx_valid),
        .o_mag   (dx_mag),
        .o_meta  (dx_meta)
    );

    psv_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_num   (r8_ny),
        .i_den   (r8_len),
        .i_meta  (r8_my),
        .o_valid (dy_valid),
        .o_mag   (dy_mag),
        .o_meta  (dy_meta)
    );

    psv_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_num   (r8_nz),
        .i_den   (r8_len),
        .i_meta  (r8_mz),
        .o_valid (dz_valid),
        .o_mag   (dz_mag),
        .o_meta  (dz_meta)
    );

    always_comb begin
        push = en && dx_valid && dy_valid && dz_valid;
        if (dx_meta.zero) begin
            p_sx = '0;
        end else begin
            p_sx = dx_meta.neg ? -SXY_W'(dx_mag) : SXY_W'(dx_mag);
        end
        if (dy_meta.zero) begin
            p_sy = '0;
        end else begin
            p_sy = dy_meta.neg ? -SXY_W'(dy_mag) : SXY_W'(dy_mag);
        end
        if (dz_meta.zero) begin
            p_sz = '0;
        end else begin
            p_sz = dz_meta.neg ? -SZ_W'(dz_mag) : SZ_W'(dz_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (!r_o_valid || !i_stall) begin
            if (r_sk_valid) begin
                r_o_valid  <= 1'b1;
                r_sk_valid <= 1'b0;
            end else begin
                r_o_valid <= push;
            end
        end else if (push) begin
            r_sk_valid <= 1'b1;
        end
        if (!r_o_valid || !i_stall) begin
            if (r_sk_valid) begin
                r_o_sx <= r_sk_sx;
                r_o_sy <= r_sk_sy;
                r_o_sz <= r_sk_sz;
            end else begin
                r_o_sx <= p_sx;
                r_o_sy <= p_sy;
                r_o_sz <= p_sz;
            end
        end else if (push) begin
            r_sk_sx <= p_sx;
            r_sk_sy <= p_sy;
            r_sk_sz <= p_sz;
        end
    end

    assign o_valid = r_o_valid;
    assign o_s_x   = r_o_sx;
    assign o_s_y   = r_o_sy;
    assign o_s_z   = r_o_sz;

    localparam logic signed [SXY_W-1:0] SXY_MAX = SXY_W'(S_LIM);
    localparam logic signed [SXY_W-1:0] SXY_MIN = -SXY_W'(S_LIM);

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_o_valid)
        else $error("Skid register holds a request while the output register is empty.");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_o_valid && i_stall))
        else $error("Skid register filled without an output stall.");

    a_sz_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_s_z) <= 0))
        else $error("The z component of the scattering vector is positive.");

    a_sx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_s_x) <= SXY_MAX && $signed(o_s_x) >= SXY_MIN))
        else $error("The x component of the scattering vector is out of range.");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dx_valid == dy_valid) && (dx_valid == dz_valid))
        else $error("Divider lanes lost alignment.");

endmodule
